[hw/rtl/mmc_pkg.sv]
// Package for the multi-mode checksum block: word types, mode codes,
// register indexes, reset values and the bitwise CRC byte-update functions.
// No dependencies.
package mmc_pkg;

   // checksum modes
   typedef enum logic [2:0] {
      MODE_SUM8  = 3'd0,
      MODE_SUM16 = 3'd1,
      MODE_CRC16 = 3'd2,
      MODE_CRC32 = 3'd3,
      MODE_XOR8  = 3'd4,
      MODE_XOR16 = 3'd5,
      MODE_ADD8  = 3'd6,
      MODE_ADD16 = 3'd7
   } mode_type;

   // register indexes on the csr port
   localparam logic [2:0] CSR_MODE         = 3'd0;
   localparam logic [2:0] CSR_START_OFFSET = 3'd1;
   localparam logic [2:0] CSR_END_OFFSET   = 3'd2;
   localparam logic [2:0] CSR_CHECK_OFFSET = 3'd3;
   localparam logic [2:0] CSR_CRC16_POLY   = 3'd4;
   localparam logic [2:0] CSR_CRC16_INIT   = 3'd5;
   localparam logic [2:0] CSR_CRC32_POLY   = 3'd6;

   localparam int OFFSET_BITS = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [15:0] CRC16_POLY_RESET = 16'h1021;
   localparam logic [15:0] CRC16_INIT_RESET = 16'hFFFF;
   localparam logic [31:0] CRC32_POLY_RESET = 32'hEDB88320;
   localparam logic [31:0] CRC32_INIT       = 32'hFFFFFFFF;

   // configuration registers
   typedef struct packed {
      mode_type                 mode;
      logic [OFFSET_BITS-1:0]   start_offset;
      logic [OFFSET_BITS-1:0]   end_offset;
      logic [OFFSET_BITS-1:0]   check_offset;
      logic [15:0]              crc16_poly;
      logic [15:0]              crc16_init;
      logic [31:0]              crc32_poly;
   } cfg_type;

   // input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   // result word
   typedef struct packed {
      logic [31:0] checksum;
      logic [31:0] stored_value;
      logic        match;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       first;      // position zero: load mode start value
      logic       active;     // position not saturated
      logic       odd;        // odd position: high byte of a pair
      logic       in_win;     // byte inside the window
      logic       pair_ok;    // pair ending here lies inside the window
      logic       cap_valid;  // byte is one of the four stored bytes
      logic [1:0] cap_idx;    // byte lane of the stored value
   } item_type;

   // MSB-first CRC-16, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  b,
                                              input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ poly;
         else c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [7:0]  b,
                                              input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'h000000, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = {1'b0, c[31:1]} ^ poly;
         else c = {1'b0, c[31:1]};
      end
      return c;
   endfunction

endpackage

[hw/rtl/mmc_fifo.sv]
// Small first-word-fall-through queue of flip-flops.
// Used between front and back and on the result side; no package needed.
module mmc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("fifo count above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("fifo push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("fifo pop while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("fifo count did not advance on push");
`endif

endmodule

[hw/rtl/mmc_front.sv]
// Front of the checksum block: byte position counter and classification
// of each accepted byte against the window and check offset. Uses mmc_pkg.
module mmc_front #(
   parameter int POSITION_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  mmc_pkg::cfg_type  cfg,
   input  logic              req_push,
   input  mmc_pkg::req_type  req_word,
   input  logic              q_full,
   output logic              q_push,
   output mmc_pkg::item_type q_item
);

   localparam int CMP_BITS = 33;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [CMP_BITS-1:0] p_ext, pair_ext, start_ext, end_ext, check_ext, cap_diff;
   logic before_end;

   assign q_push = req_push && !q_full;

   // window and capture compares
   always_comb begin
      p_ext     = CMP_BITS'(position_ff);
      pair_ext  = {p_ext[CMP_BITS-1:1], 1'b0};
      start_ext = CMP_BITS'(cfg.start_offset);
      end_ext   = CMP_BITS'(cfg.end_offset);
      check_ext = CMP_BITS'(cfg.check_offset);
      cap_diff  = p_ext - check_ext;
      before_end = (cfg.end_offset == '0) || (p_ext < end_ext);

      q_item.data_byte = req_word.data_byte;
      q_item.last      = req_word.last;
      q_item.first     = (position_ff == '0);
      q_item.active    = (position_ff != POS_MAX);
      q_item.odd       = position_ff[0];
      q_item.in_win    = (p_ext >= start_ext) && before_end;
      q_item.pair_ok   = (pair_ext >= start_ext) && before_end;
      q_item.cap_valid = (p_ext >= check_ext) && (cap_diff < CMP_BITS'(4));
      q_item.cap_idx   = cap_diff[1:0];
   end

   // position counter: saturates, clears after the last byte
   always_comb begin
      position_in = position_ff;
      if (q_push) begin
         if (req_word.last) begin
            position_in = '0;
         end else if (position_ff != POS_MAX) begin
            position_in = position_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
      end else begin
         position_ff <= position_in;
      end
   end

endmodule

[hw/rtl/mmc_back.sv]
// Back of the checksum block: accumulator, pair buffer and stored-value
// capture; forms the result word on the last byte. Uses mmc_pkg.
module mmc_back (
   input  logic              clock,
   input  logic              reset,
   input  mmc_pkg::cfg_type  cfg,
   input  logic              q_empty,
   input  mmc_pkg::item_type q_item,
   output logic              q_pop,
   input  logic              out_full,
   output logic              out_push,
   output mmc_pkg::rsp_type  out_word
);

   logic [31:0] acc_ff, acc_in;
   logic [7:0]  pend_ff, pend_in;
   logic [31:0] cap_ff, cap_in;
   logic [2:0]  seen_ff, seen_in;
   logic [31:0] start_value;
   logic [15:0] pair_word;
   logic        fire;

   assign fire     = !q_empty && !out_full;
   assign q_pop    = fire;
   assign out_push = fire && q_item.last;

   // mode start value
   always_comb begin
      case (cfg.mode)
         mmc_pkg::MODE_CRC16: start_value = {16'h0000, cfg.crc16_init};
         mmc_pkg::MODE_CRC32: start_value = mmc_pkg::CRC32_INIT;
         default:             start_value = '0;
      endcase
   end

   // fold one byte
   always_comb begin
      acc_in    = q_item.first ? start_value : acc_ff;
      pend_in   = pend_ff;
      cap_in    = cap_ff;
      seen_in   = seen_ff;
      pair_word = {q_item.data_byte, pend_ff};
      if (q_item.active) begin
         if (!q_item.odd) begin
            pend_in = q_item.data_byte;
         end else if (q_item.pair_ok && (cfg.mode inside
                      {mmc_pkg::MODE_SUM16, mmc_pkg::MODE_XOR16, mmc_pkg::MODE_ADD16})) begin
            if (cfg.mode == mmc_pkg::MODE_XOR16) begin
               acc_in = {16'h0000, acc_in[15:0] ^ pair_word};
            end else begin
               acc_in = {16'h0000, acc_in[15:0] + pair_word};
            end
         end
         if (q_item.in_win) begin
            case (cfg.mode)
               mmc_pkg::MODE_SUM8, mmc_pkg::MODE_ADD8: begin
                  acc_in = {24'h000000, acc_in[7:0] + q_item.data_byte};
               end
               mmc_pkg::MODE_CRC16: begin
                  acc_in = {16'h0000, mmc_pkg::crc16_byte(acc_in[15:0],
                            q_item.data_byte, cfg.crc16_poly)};
               end
               mmc_pkg::MODE_CRC32: begin
                  acc_in = mmc_pkg::crc32_byte(acc_in, q_item.data_byte,
                                               cfg.crc32_poly);
               end
               mmc_pkg::MODE_XOR8: begin
                  acc_in = {24'h000000, acc_in[7:0] ^ q_item.data_byte};
               end
               default: begin
               end
            endcase
         end
         if (q_item.cap_valid) begin
            cap_in  = cap_ff | (32'(q_item.data_byte) << {q_item.cap_idx, 3'b000});
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   // result word
   always_comb begin
      case (cfg.mode)
         mmc_pkg::MODE_SUM8, mmc_pkg::MODE_XOR8, mmc_pkg::MODE_ADD8: begin
            out_word.checksum = {24'h000000, acc_in[7:0]};
         end
         mmc_pkg::MODE_CRC32: out_word.checksum = ~acc_in;
         default:             out_word.checksum = {16'h0000, acc_in[15:0]};
      endcase
      if (cfg.mode == mmc_pkg::MODE_CRC32) begin
         out_word.stored_value = (seen_in >= 3'd4) ? cap_in : '0;
      end else if (seen_in >= 3'd2) begin
         out_word.stored_value = {16'h0000, cap_in[15:0]};
      end else if (seen_in >= 3'd1) begin
         out_word.stored_value = {24'h000000, cap_in[7:0]};
      end else begin
         out_word.stored_value = '0;
      end
      out_word.match = (seen_in != 3'd0) &&
                       (out_word.checksum == out_word.stored_value);
   end

   // stream state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
         cap_ff  <= '0;
         seen_ff <= '0;
      end else if (fire) begin
         if (q_item.last) begin
            acc_ff  <= '0;
            pend_ff <= '0;
            cap_ff  <= '0;
            seen_ff <= '0;
         end else begin
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
            cap_ff  <= cap_in;
            seen_ff <= seen_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= 3'd4) else $error("more than four stored bytes captured");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && q_item.last) |=> (seen_ff == 3'd0 && cap_ff == '0))
      else $error("capture not cleared after last byte");
`endif

endmodule

[hw/rtl/multi_mode_checksum.sv]
// Top level of the multi-mode checksum block: configuration registers,
// front classifier, byte queue, back accumulator and result queue.
// Uses mmc_pkg, mmc_front, mmc_back and mmc_fifo.
//
// Usage:
//  - Input words (data_byte, last) are pushed with req_push while req_full
//    is low; one byte is accepted per cycle. A byte with last set closes
//    the image and produces one result word; other bytes produce none.
//  - Results (checksum, stored_value, match) wait in a two-entry queue;
//    rsp_word is valid while rsp_empty is low and is taken with rsp_pop.
//  - Registers are written through csr_wr_en / csr_index / csr_wdata; the
//    user must write them only while no image is in flight, and the block
//    does not enforce this. Index 7 is ignored.
//  - A last byte passes through the byte queue; the back unit forms the
//    result word combinationally as the byte leaves the queue.
//  - Throughput: one byte per cycle while the result queue has room; the back
//    unit folds each byte combinationally (eight-step bitwise CRC included).
//  - When the receiver stalls, the result queue fills, the back unit stops,
//    the byte queue (QUEUE_DEPTH entries) fills and req_full rises.
//  - Synchronous reset clears the position counter, accumulator and both
//    queues and returns all registers to their reset values.
module multi_mode_checksum #(
   parameter int POSITION_BITS = 24,
   parameter int QUEUE_DEPTH   = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  mmc_pkg::req_type                    req_word,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output mmc_pkg::rsp_type                    rsp_word,
   input  logic                                csr_wr_en,
   input  logic [mmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mmc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int RSP_DEPTH = 2;

   mmc_pkg::cfg_type  cfg_ff;
   mmc_pkg::item_type front_item, back_item;
   mmc_pkg::rsp_type  back_word;
   logic front_push, q_full, q_empty, q_pop;
   logic out_push, out_full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= mmc_pkg::MODE_SUM8;
         cfg_ff.start_offset <= '0;
         cfg_ff.end_offset   <= '0;
         cfg_ff.check_offset <= '0;
         cfg_ff.crc16_poly   <= mmc_pkg::CRC16_POLY_RESET;
         cfg_ff.crc16_init   <= mmc_pkg::CRC16_INIT_RESET;
         cfg_ff.crc32_poly   <= mmc_pkg::CRC32_POLY_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            mmc_pkg::CSR_MODE:
               cfg_ff.mode <= mmc_pkg::mode_type'(csr_wdata[2:0]);
            mmc_pkg::CSR_START_OFFSET:
               cfg_ff.start_offset <= csr_wdata[mmc_pkg::OFFSET_BITS-1:0];
            mmc_pkg::CSR_END_OFFSET:
               cfg_ff.end_offset <= csr_wdata[mmc_pkg::OFFSET_BITS-1:0];
            mmc_pkg::CSR_CHECK_OFFSET:
               cfg_ff.check_offset <= csr_wdata[mmc_pkg::OFFSET_BITS-1:0];
            mmc_pkg::CSR_CRC16_POLY:
               cfg_ff.crc16_poly <= csr_wdata[15:0];
            mmc_pkg::CSR_CRC16_INIT:
               cfg_ff.crc16_init <= csr_wdata[15:0];
            mmc_pkg::CSR_CRC32_POLY:
               cfg_ff.crc32_poly <= csr_wdata[31:0];
            default: begin
            end
         endcase
      end
   end

   assign req_full = q_full;

   // front: position and classification
   mmc_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_word (req_word),
      .q_full   (q_full),
      .q_push   (front_push),
      .q_item   (front_item)
   );

   // byte queue between front and back
   mmc_fifo #(
      .WIDTH($bits(mmc_pkg::item_type)),
      .DEPTH(QUEUE_DEPTH)
   ) u_item_q (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_item),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (back_item),
      .empty (q_empty)
   );

   // back: accumulator and result
   mmc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_empty  (q_empty),
      .q_item   (back_item),
      .q_pop    (q_pop),
      .out_full (out_full),
      .out_push (out_push),
      .out_word (back_word)
   );

   // result queue
   mmc_fifo #(
      .WIDTH($bits(mmc_pkg::rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_word),
      .full  (out_full),
      .pop   (rsp_pop && !rsp_empty),
      .rdata (rsp_word),
      .empty (rsp_empty)
   );

endmodule
